// ===== sv/jtdm_pkg.sv =====
// Shared types and constants for the joystick tank drive mixer.
package jtdm_pkg;

  localparam int unsigned PosW  = 10;
  localparam int unsigned DutyW = 8;
  localparam int unsigned DbW   = 9;
  localparam int unsigned DiffW = PosW + 1;

  localparam logic [PosW-1:0] POS_CENTRE = 10'd512;
  localparam logic [PosW-1:0] POS_FULL   = 10'd1023;
  localparam logic [PosW-1:0] POS_HALF   = 10'd511;

  // Configuration register indexes
  localparam logic CFG_DEAD_BAND = 1'b0;
  localparam logic CFG_MAX_DUTY  = 1'b1;

  // Operands of one range map: num = v - lo, den = hi - lo.
  // from_top set means the map runs from max_duty down to zero.
  typedef struct packed {
    logic signed [DiffW-1:0] num;
    logic signed [DiffW-1:0] den;
    logic                    from_top;
  } map_req_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_ZERO,
    K_MAP
  } duty_kind_e;

  typedef enum logic [1:0] {
    MAP_IDLE,
    MAP_PREP,
    MAP_DIV,
    MAP_DONE
  } map_state_e;

  typedef enum logic [2:0] {
    MIX_IDLE,
    MIX_LGO,
    MIX_LWAIT,
    MIX_RGO,
    MIX_RWAIT,
    MIX_OUT
  } mix_state_e;

endpackage

// ===== sv/jtdm_map.sv =====
// Range map unit: scale by max_duty, then a bit-serial restoring divide and clamp.
module jtdm_map import jtdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  map_req_t         req_i,
  input  logic [DutyW-1:0] max_duty_i,
  output logic             done_o,
  output logic [DutyW-1:0] duty_o
);

  map_state_e state_q, state_d;
  map_req_t   req_q;
  logic [2:0]       cnt_q;
  logic [PosW-1:0]  rem_q;
  logic [DutyW-1:0] quo_q;
  logic [PosW-1:0]  den_mag_q;
  logic             zero_q, ovf_q, den_zero_q;

  logic [PosW-1:0]        num_mag, den_mag;
  logic [PosW+DutyW-1:0]  prod;
  logic [PosW:0]          trial;
  logic                   trial_ge;
  logic [DutyW-1:0]       quot;

  assign num_mag  = req_q.num[DiffW-1] ? PosW'(-req_q.num) : PosW'(req_q.num);
  assign den_mag  = req_q.den[DiffW-1] ? PosW'(-req_q.den) : PosW'(req_q.den);
  assign prod     = (PosW+DutyW)'(num_mag) * (PosW+DutyW)'(max_duty_i);
  assign trial    = {rem_q, quo_q[DutyW-1]};
  assign trial_ge = trial >= {1'b0, den_mag_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      MAP_IDLE: if (start_i) state_d = MAP_PREP;
      MAP_PREP: state_d = MAP_DIV;
      MAP_DIV:  if (cnt_q == 3'd7) state_d = MAP_DONE;
      MAP_DONE: state_d = MAP_IDLE;
      default:  state_d = MAP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MAP_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MAP_DIV) cnt_q <= cnt_q + 3'd1;
      else                    cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MAP_IDLE: begin
        if (start_i) req_q <= req_i;
      end
      MAP_PREP: begin
        rem_q      <= prod[PosW+DutyW-1:DutyW];
        quo_q      <= prod[DutyW-1:0];
        den_mag_q  <= den_mag;
        ovf_q      <= prod[PosW+DutyW-1:DutyW] >= den_mag;
        // a negative quotient acts as zero after the clamp
        zero_q     <= (req_q.num == '0) || (req_q.num[DiffW-1] ^ req_q.den[DiffW-1]);
        den_zero_q <= req_q.den == '0;
      end
      MAP_DIV: begin
        rem_q <= trial_ge ? PosW'(trial - {1'b0, den_mag_q}) : trial[PosW-1:0];
        quo_q <= {quo_q[DutyW-2:0], trial_ge};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    done_o = state_q == MAP_DONE;
    if (zero_q)     quot = '0;
    else if (ovf_q) quot = '1;
    else            quot = quo_q;
    if (den_zero_q) begin
      duty_o = req_q.from_top ? max_duty_i : '0;
    end else if (req_q.from_top) begin
      duty_o = (quot > max_duty_i) ? '0 : DutyW'(max_duty_i - quot);
    end else begin
      duty_o = (quot > max_duty_i) ? max_duty_i : quot;
    end
  end

endmodule

// ===== sv/joystick_tank_drive_mixer.sv =====
// Top level: joystick position to differential drive duties and direction bits.
//
// Usage: present x_pos_i / y_pos_i with in_valid_i; a transaction happens when
// in_valid_i and in_ready_o are both high. One result transaction follows on
// the output channel (out_valid_o / out_ready_i) for every input transaction.
// The block works on one position at a time. Both duty maps share one range
// map unit, which runs each map in steps (start, scale, 8 quotient bits one
// per cycle, done); the left map runs first, then the right, and then the
// result is loaded into the output register.
// If the receiver stalls, the finished result waits in the output register
// and the next position is computed; it is held back until the output
// register frees up.
// Positions that no rule covers repeat the last delivered outputs.
// The configuration port writes dead_band (index 0) and max_duty (index 1)
// at any clock edge with cfg_we_i high; change them only while idle.
// Reset: dead_band = 50, max_duty = 255, stored outputs cleared to zero,
// no result pending.
module joystick_tank_drive_mixer import jtdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [DbW-1:0]   cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PosW-1:0]  x_pos_i,
  input  logic [PosW-1:0]  y_pos_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DutyW-1:0] left_duty_o,
  output logic [DutyW-1:0] right_duty_o,
  output logic             dir_a_o,
  output logic             dir_b_o
);

  function automatic map_req_t mk_req(input logic [PosW-1:0] v, input logic [PosW-1:0] lo,
                                      input logic [PosW-1:0] hi, input logic from_top);
    map_req_t r;
    r.num      = $signed({1'b0, v}) - $signed({1'b0, lo});
    r.den      = $signed({1'b0, hi}) - $signed({1'b0, lo});
    r.from_top = from_top;
    return r;
  endfunction

  mix_state_e state_q, state_d;

  logic [DbW-1:0]   dead_band_q;
  logic [DutyW-1:0] max_duty_q;

  logic             out_valid_q;
  logic [DutyW-1:0] left_q, right_q;
  logic             dir_a_q, dir_b_q;

  duty_kind_e lkind_q, rkind_q, lkind_d, rkind_d;
  map_req_t   lreq_q, rreq_q, lreq_d, rreq_d;
  logic       da_q, db_q, da_d, db_d;
  logic [DutyW-1:0] lres_q, rres_q;

  logic             accept, out_load;
  logic             map_start, map_done;
  map_req_t         map_req;
  logic [DutyW-1:0] map_duty;

  logic [PosW-1:0] hi_b, lo_b, ref_y, ref_x;
  logic            band_x, band_y, strict_x, strict_y;

  assign hi_b     = PosW'(POS_CENTRE + PosW'(dead_band_q));
  assign lo_b     = PosW'(POS_CENTRE - PosW'(dead_band_q));
  assign ref_y    = PosW'(POS_FULL - y_pos_i);
  assign ref_x    = PosW'(POS_FULL - x_pos_i);
  assign band_x   = (x_pos_i <= hi_b) && (x_pos_i >= lo_b);
  assign band_y   = (y_pos_i <= hi_b) && (y_pos_i >= lo_b);
  assign strict_x = (x_pos_i < hi_b) && (x_pos_i > lo_b);
  assign strict_y = (y_pos_i < hi_b) && (y_pos_i > lo_b);

  // Region decode: pick direction bits and the two map operands
  always_comb begin
    lkind_d = K_HOLD;
    rkind_d = K_HOLD;
    lreq_d  = mk_req(x_pos_i, POS_CENTRE, POS_FULL, 1'b0);
    rreq_d  = lreq_d;
    da_d    = dir_a_q;
    db_d    = dir_b_q;
    if (band_x && band_y) begin
      lkind_d = K_ZERO;
      rkind_d = K_ZERO;
      da_d    = 1'b1;
      db_d    = 1'b1;
    end else if (strict_x) begin
      if (y_pos_i > hi_b) begin
        lkind_d = K_MAP;
        lreq_d  = mk_req(y_pos_i, POS_CENTRE, POS_FULL, 1'b0);
        da_d    = 1'b0;
        db_d    = 1'b0;
      end else if (y_pos_i < lo_b) begin
        lkind_d = K_MAP;
        lreq_d  = mk_req(y_pos_i, '0, POS_HALF, 1'b1);
        da_d    = 1'b1;
        db_d    = 1'b1;
      end
      rkind_d = lkind_d;
      rreq_d  = lreq_d;
    end else if (strict_y) begin
      if (x_pos_i > hi_b) begin
        lkind_d = K_MAP;
        lreq_d  = mk_req(x_pos_i, POS_CENTRE, POS_FULL, 1'b0);
        da_d    = 1'b0;
        db_d    = 1'b1;
      end else if (x_pos_i < lo_b) begin
        lkind_d = K_MAP;
        lreq_d  = mk_req(x_pos_i, '0, POS_HALF, 1'b1);
        da_d    = 1'b1;
        db_d    = 1'b0;
      end
      rkind_d = lkind_d;
      rreq_d  = lreq_d;
    end else if (y_pos_i < lo_b) begin
      if (x_pos_i > hi_b) begin
        lkind_d = K_MAP;
        rkind_d = K_MAP;
        if (x_pos_i < ref_y) begin
          da_d   = 1'b1;
          db_d   = 1'b1;
          lreq_d = mk_req(y_pos_i, '0, POS_HALF, 1'b1);
          rreq_d = mk_req(x_pos_i, POS_CENTRE, ref_y, 1'b1);
        end else begin
          da_d   = 1'b0;
          db_d   = 1'b1;
          lreq_d = mk_req(x_pos_i, POS_CENTRE, POS_FULL, 1'b0);
          rreq_d = mk_req(y_pos_i, ref_x, POS_HALF, 1'b0);
        end
      end else if (x_pos_i < lo_b) begin
        lkind_d = K_MAP;
        rkind_d = K_MAP;
        if (x_pos_i > y_pos_i) begin
          da_d   = 1'b1;
          db_d   = 1'b1;
          rreq_d = mk_req(y_pos_i, '0, POS_HALF, 1'b1);
          lreq_d = mk_req(x_pos_i, y_pos_i, POS_HALF, 1'b0);
        end else begin
          da_d   = 1'b1;
          db_d   = 1'b0;
          rreq_d = mk_req(x_pos_i, '0, POS_HALF, 1'b1);
          lreq_d = mk_req(y_pos_i, x_pos_i, POS_HALF, 1'b0);
        end
      end
    end else begin
      lkind_d = K_MAP;
      rkind_d = K_MAP;
      if (x_pos_i < lo_b) begin
        if (x_pos_i > ref_y) begin
          da_d   = 1'b0;
          db_d   = 1'b0;
          lreq_d = mk_req(y_pos_i, POS_CENTRE, POS_FULL, 1'b0);
          rreq_d = mk_req(x_pos_i, ref_y, POS_HALF, 1'b0);
        end else begin
          da_d   = 1'b1;
          db_d   = 1'b0;
          lreq_d = mk_req(x_pos_i, '0, POS_HALF, 1'b1);
          rreq_d = mk_req(y_pos_i, POS_CENTRE, ref_x, 1'b1);
        end
      end else begin
        if (x_pos_i > y_pos_i) begin
          da_d   = 1'b0;
          db_d   = 1'b1;
          rreq_d = mk_req(x_pos_i, POS_CENTRE, POS_FULL, 1'b0);
          lreq_d = mk_req(y_pos_i, POS_CENTRE, x_pos_i, 1'b1);
        end else begin
          da_d   = 1'b0;
          db_d   = 1'b0;
          rreq_d = mk_req(y_pos_i, POS_CENTRE, POS_FULL, 1'b0);
          lreq_d = mk_req(x_pos_i, POS_CENTRE, y_pos_i, 1'b1);
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      MIX_IDLE:  if (in_valid_i) state_d = MIX_LGO;
      MIX_LGO:   state_d = MIX_LWAIT;
      MIX_LWAIT: if (map_done) state_d = MIX_RGO;
      MIX_RGO:   state_d = MIX_RWAIT;
      MIX_RWAIT: if (map_done) state_d = MIX_OUT;
      MIX_OUT:   if (!out_valid_q || out_ready_i) state_d = MIX_IDLE;
      default:   state_d = MIX_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = state_q == MIX_IDLE;
    map_start  = (state_q == MIX_LGO) || (state_q == MIX_RGO);
    map_req    = (state_q == MIX_RGO) ? rreq_q : lreq_q;
    out_load   = (state_q == MIX_OUT) && (!out_valid_q || out_ready_i);
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= MIX_IDLE;
      dead_band_q <= DbW'(50);
      max_duty_q  <= DutyW'(255);
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      dir_a_q     <= 1'b0;
      dir_b_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEAD_BAND: dead_band_q <= cfg_data_i;
          CFG_MAX_DUTY:  max_duty_q  <= cfg_data_i[DutyW-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        // the output register doubles as the stored last outputs
        if (lkind_q != K_HOLD) begin
          dir_a_q <= da_q;
          dir_b_q <= db_q;
        end
        case (lkind_q)
          K_ZERO:  left_q <= '0;
          K_MAP:   left_q <= lres_q;
          default: left_q <= left_q;
        endcase
        case (rkind_q)
          K_ZERO:  right_q <= '0;
          K_MAP:   right_q <= rres_q;
          default: right_q <= right_q;
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lkind_q <= lkind_d;
      rkind_q <= rkind_d;
      lreq_q  <= lreq_d;
      rreq_q  <= rreq_d;
      da_q    <= da_d;
      db_q    <= db_d;
    end
    if (map_done && state_q == MIX_LWAIT) lres_q <= map_duty;
    if (map_done && state_q == MIX_RWAIT) rres_q <= map_duty;
  end

  jtdm_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (map_start),
    .req_i      (map_req),
    .max_duty_i (max_duty_q),
    .done_o     (map_done),
    .duty_o     (map_duty)
  );

  assign out_valid_o  = out_valid_q;
  assign left_duty_o  = left_q;
  assign right_duty_o = right_q;
  assign dir_a_o      = dir_a_q;
  assign dir_b_o      = dir_b_q;

endmodule
